[src/upd_pkg.sv]
// upd_pkg: shared types, character constants and hex helpers for the url percent decoder
// depends on nothing; imported by every module of the decoder
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] NOT_HEX    = 8'hFF;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_PCT   = 2'd1,
        HELD_DIGIT = 2'd2
    } t_held;

    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic [2:0]      has;
        logic            last;
    } t_group;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                v = c - 8'h41 + 8'd10;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                v = c - 8'h61 + 8'd10;
            end else begin
                v = NOT_HEX;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

[src/upd_decoder.sv]
// upd_decoder: combinational decode of one registered byte against the held escape state
// depends on upd_pkg; produces a group of up to three results and the next held state
`timescale 1ns / 1ps
`default_nettype none

module upd_decoder (
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    input  wire upd_pkg::t_held i_held,
    input  wire logic [7:0]     i_held_digit,
    output upd_pkg::t_group     o_group,
    output upd_pkg::t_held      o_next_held,
    output logic [7:0]          o_next_digit
);
    import upd_pkg::*;

    logic [3:0][7:0] e;
    logic [2:0]      n;
    logic [7:0]      hv;
    logic [7:0]      hi;
    logic [7:0]      v;
    t_held           held;
    logic [7:0]      digit;

    always_comb begin
        e     = '0;
        n     = 3'd0;
        hv    = hex_value(i_byte);
        hi    = hex_value(i_held_digit);
        v     = {hi[3:0], hv[3:0]};
        held  = HELD_NONE;
        digit = i_held_digit;

        unique case (i_held)
            HELD_PCT: begin
                if (hv != NOT_HEX) begin
                    held  = HELD_DIGIT;
                    digit = i_byte;
                end else begin
                    e[n[1:0]] = PCT_CHAR;
                    n = n + 3'd1;
                    if (i_byte == PCT_CHAR) begin
                        held = HELD_PCT;
                    end else begin
                        e[n[1:0]] = (i_byte == PLUS_CHAR) ? SPACE_CHAR : i_byte;
                        n = n + 3'd1;
                    end
                end
            end
            HELD_DIGIT: begin
                if (hv != NOT_HEX && hi != NOT_HEX) begin
                    if (v != 8'h00) begin
                        e[n[1:0]] = v;
                        n = n + 3'd1;
                    end
                end else begin
                    e[n[1:0]] = PCT_CHAR;
                    n = n + 3'd1;
                    if (i_held_digit == PCT_CHAR) begin
                        held = HELD_PCT;
                    end else begin
                        e[n[1:0]] = (i_held_digit == PLUS_CHAR) ? SPACE_CHAR : i_held_digit;
                        n = n + 3'd1;
                    end
                    if (i_byte == PCT_CHAR) begin
                        held = HELD_PCT;
                    end else begin
                        e[n[1:0]] = (i_byte == PLUS_CHAR) ? SPACE_CHAR : i_byte;
                        n = n + 3'd1;
                    end
                end
                digit = 8'h00;
            end
            default: begin
                if (i_byte == PCT_CHAR) begin
                    held = HELD_PCT;
                end else begin
                    e[n[1:0]] = (i_byte == PLUS_CHAR) ? SPACE_CHAR : i_byte;
                    n = n + 3'd1;
                end
            end
        endcase

        // end of string flushes what is held
        if (i_last) begin
            if (held == HELD_PCT || held == HELD_DIGIT) begin
                if (n < 3'd4) begin
                    e[n[1:0]] = PCT_CHAR;
                    n = n + 3'd1;
                end
            end
            if (held == HELD_DIGIT) begin
                if (n < 3'd4) begin
                    e[n[1:0]] = digit;
                    n = n + 3'd1;
                end
            end
            held  = HELD_NONE;
            digit = 8'h00;
        end

        if (n > 3'(MAX_RESULTS)) begin
            n = 3'(MAX_RESULTS);
        end

        o_group.bytes = {e[2], e[1], e[0]};
        o_group.last  = i_last;
        if (i_last && n == 3'd0) begin
            o_group.count = 2'd1;
            o_group.bytes = '0;
            o_group.has   = 3'b000;
        end else begin
            o_group.count = n[1:0];
            o_group.has   = {(n > 3'd2), (n > 3'd1), (n > 3'd0)};
        end
        o_next_held  = held;
        o_next_digit = digit;
    end

endmodule

`default_nettype wire

[src/upd_out_queue.sv]
// upd_out_queue: result register that holds one group and hands out its results in order
// depends on upd_pkg; fed by the decoder group, drives the output channel
`timescale 1ns / 1ps
`default_nettype none

module upd_out_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire upd_pkg::t_group i_group,
    output logic                 o_free,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_has_byte,
    output logic                 o_out_last
);
    import upd_pkg::*;

    logic [1:0]      r_cnt;
    logic [2:0][7:0] r_bytes;
    logic [2:0]      r_has;
    logic            r_last;
    logic            w_pop;

    assign w_pop  = (r_cnt != 2'd0) && !i_out_stall;
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_group.bytes;
            r_has   <= i_group.has;
            r_last  <= i_group.last;
        end else if (w_pop) begin
            r_bytes <= {8'h00, r_bytes[2], r_bytes[1]};
            r_has   <= {1'b0, r_has[2], r_has[1]};
        end
    end

    assign o_out_valid    = (r_cnt != 2'd0);
    assign o_out_byte     = r_bytes[0];
    assign o_out_has_byte = r_has[0];
    assign o_out_last     = r_last && (r_cnt == 2'd1);

endmodule

`default_nettype wire

[src/url_percent_decoder.sv]
// url_percent_decoder: top level, input register, held escape state, decoder and result queue
// depends on upd_pkg, upd_decoder and upd_out_queue
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_byte, i_in_last
//  out     | output    | o_out_valid / i_out_stall | o_out_byte, o_out_has_byte, o_out_last
//
// one byte per cycle when each byte yields at most one result and the output does not stall
// a byte that yields two or three results holds the input until the result queue
// is down to its last result; the queue drains one transaction per cycle when not stalled
// an accepted byte passes the input register, then the result queue register, to its first result
// reset is synchronous; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_has_byte,
    output logic            o_out_last
);
    import upd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_held      r_held;
    logic [7:0] r_held_digit;

    t_group     w_group;
    t_held      n_held;
    logic [7:0] n_held_digit;
    logic       w_free;
    logic       w_advance;
    logic       w_load;

    upd_decoder u_decoder (
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_held       (r_held),
        .i_held_digit (r_held_digit),
        .o_group      (w_group),
        .o_next_held  (n_held),
        .o_next_digit (n_held_digit)
    );

    // groups with no result only update the held state
    assign w_advance  = r_in_valid && ((w_group.count == 2'd0) || w_free);
    assign w_load     = w_advance && (w_group.count != 2'd0);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_held       <= HELD_NONE;
            r_held_digit <= 8'h00;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_held       <= n_held;
                r_held_digit <= n_held_digit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    upd_out_queue u_out_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_group        (w_group),
        .o_free         (w_free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_has_byte (o_out_has_byte),
        .o_out_last     (o_out_last)
    );

endmodule

`default_nettype wire

[tb/url_percent_decoder_tb.sv]
// url_percent_decoder_tb: self-checking testbench for the url percent decoder
// drives raw url bytes with random idle and stall, predicts decoded bytes in a scoreboard class
// depends on upd_pkg and url_percent_decoder
`timescale 1ns / 1ps

module url_percent_decoder_tb;
    import upd_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int ITEM_TARGET = 430;

    class decode_checker;
        typedef struct {
            logic [7:0] data;
            logic       has_byte;
            logic       last;
        } t_result;

        t_result    decoded_queue[$];
        logic [7:0] emitted[$];
        t_held      held;
        logic [7:0] digit;
        int         errors;

        function new();
            held   = HELD_NONE;
            digit  = '0;
            errors = 0;
        endfunction

        function bit is_hex(input logic [7:0] c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                   (c >= 8'h61 && c <= 8'h66);
        endfunction

        function logic [3:0] nibble(input logic [7:0] c);
            if (c <= 8'h39) begin
                return c[3:0];
            end
            return c[3:0] + 4'd9;
        endfunction

        function void add_emit(input logic [7:0] b);
            emitted.insert(emitted.size(), b);
        endfunction

        function void plain_byte(input logic [7:0] b);
            if (b == PCT_CHAR) begin
                held = HELD_PCT;
            end else if (b == PLUS_CHAR) begin
                add_emit(SPACE_CHAR);
            end else begin
                add_emit(b);
            end
        endfunction

        function int pending();
            return decoded_queue.size();
        endfunction

        // works out the results of one accepted input transaction
        function void predict_decode(input logic [7:0] b, input logic l);
            logic [7:0] v;
            t_result    r;
            emitted.delete();
            case (held)
                HELD_PCT: begin
                    if (is_hex(b)) begin
                        digit = b;
                        held  = HELD_DIGIT;
                    end else begin
                        add_emit(PCT_CHAR);
                        held = HELD_NONE;
                        plain_byte(b);
                    end
                end
                HELD_DIGIT: begin
                    held = HELD_NONE;
                    if (is_hex(b) && is_hex(digit)) begin
                        v = {nibble(digit), nibble(b)};
                        if (v != 8'h00) begin
                            add_emit(v);
                        end
                    end else begin
                        add_emit(PCT_CHAR);
                        plain_byte(digit);
                        plain_byte(b);
                    end
                    digit = '0;
                end
                default: begin
                    held = HELD_NONE;
                    plain_byte(b);
                end
            endcase
            if (l) begin
                if (held == HELD_PCT) begin
                    add_emit(PCT_CHAR);
                end else if (held == HELD_DIGIT) begin
                    add_emit(PCT_CHAR);
                    add_emit(digit);
                end
                held  = HELD_NONE;
                digit = '0;
            end
            while (emitted.size() > MAX_RESULTS) begin
                void'(emitted.pop_back());
            end
            if (l && emitted.size() == 0) begin
                r = '{data: 8'h00, has_byte: 1'b0, last: 1'b1};
                decoded_queue.insert(decoded_queue.size(), r);
            end
            for (int k = 0; k < emitted.size(); k++) begin
                r = '{data: emitted[k], has_byte: 1'b1, last: l && (k == emitted.size() - 1)};
                decoded_queue.insert(decoded_queue.size(), r);
            end
        endfunction

        function void check_output(input logic [7:0] b, input logic has, input logic l);
            t_result want;
            if (decoded_queue.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: byte %02h has %0d last %0d", b, has, l);
                end
                return;
            end
            want = decoded_queue.pop_front();
            if (want.data !== b || want.has_byte !== has || want.last !== l) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected byte %02h has %0d last %0d, got %02h %0d %0d",
                             want.data, want.has_byte, want.last, b, has, l);
                end
            end
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_in_last      = 1'b0;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_has_byte;
    logic       o_out_last;

    logic          calm = 1'b0;
    int            quiet_cycles = 0;
    int            sent = 0;
    decode_checker sb = new();

    logic [8:0] directed_seq [0:24] = '{
        {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, PLUS_CHAR},
        {1'b0, PCT_CHAR}, {1'b0, 8'h34}, {1'b0, 8'h31},
        {1'b0, PCT_CHAR}, {1'b0, 8'h36}, {1'b0, 8'h61},
        {1'b0, PCT_CHAR}, {1'b0, 8'h30}, {1'b1, 8'h30},
        {1'b0, PCT_CHAR}, {1'b0, PCT_CHAR}, {1'b0, 8'h41}, {1'b0, PLUS_CHAR},
        {1'b0, PCT_CHAR}, {1'b0, 8'h7A}, {1'b0, PLUS_CHAR},
        {1'b0, PCT_CHAR}, {1'b1, 8'h46},
        {1'b1, PCT_CHAR},
        {1'b0, PCT_CHAR}, {1'b0, 8'h66}, {1'b1, PCT_CHAR}
    };

    url_percent_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_out_has_byte (o_out_has_byte),
        .o_out_last     (o_out_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_output(o_out_byte, o_out_has_byte, o_out_last);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic l);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= l;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.predict_decode(b, l);
        sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return 8'h30 + r[7:0];
        end else if (r < 16) begin
            return 8'h41 + r[7:0] - 8'd10;
        end
        return 8'h61 + r[7:0] - 8'd16;
    endfunction

    // well-formed escapes with random content, plus signs, %00 escapes, broken escapes and noise
    task automatic send_random_string();
        logic [7:0] s[$];
        int         units;
        int         pick;
        logic       l;
        units = $urandom_range(1, 8);
        for (int u = 0; u < units; u++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                s.insert(s.size(), PCT_CHAR);
                s.insert(s.size(), pick_hex());
                s.insert(s.size(), pick_hex());
            end else if (pick < 50) begin
                s.insert(s.size(), PLUS_CHAR);
            end else if (pick < 58) begin
                s.insert(s.size(), PCT_CHAR);
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            end else if (pick < 64) begin
                s.insert(s.size(), PCT_CHAR);
                s.insert(s.size(), pick_hex());
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            end else if (pick < 67) begin
                s.insert(s.size(), PCT_CHAR);
                s.insert(s.size(), 8'h30);
                s.insert(s.size(), 8'h30);
            end else begin
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            s.insert(s.size(), PCT_CHAR);
        end else if (pick < 16) begin
            s.insert(s.size(), PCT_CHAR);
            s.insert(s.size(), pick_hex());
        end
        for (int k = 0; k < s.size(); k++) begin
            l = (k == s.size() - 1) || ($urandom_range(0, 39) == 0);
            send_item(s[k], l);
        end
    endtask

    initial begin
        bit pressed;
        pressed = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_seq[k]) begin
            send_item(directed_seq[k][7:0], directed_seq[k][8]);
        end
        drain_results();

        while (sent < ITEM_TARGET) begin
            calm = (sent >= 150 && sent < 260);
            send_random_string();
            if (!pressed && sent >= 300) begin
                drain_results();
                pressed = 1'b1;
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
